// File: rtl/cldf_pkg.sv
// Package for the code line dedup filter: sizes, register defaults, character codes,
// register indexes, prefix type codes and the sequencer state type.
// No dependencies; every other file of the block depends on it.
package cldf_pkg;

    localparam int MAX_LINE_DEF = 64;
    localparam int ELAPSED_W    = 17;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int CODE_LEN_W   = 6;
    localparam int PREFIX_LEN   = 5;

    localparam logic [CFG_DATA_W-1:0] MIN_INTERVAL_RST  = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] REPEAT_WINDOW_RST = 16'd500;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_WINDOW = 2'd1;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam logic [8*PREFIX_LEN-1:0] ROOM_PREFIX = "ROOM:";
    localparam logic [8*PREFIX_LEN-1:0] USER_PREFIX = "USER:";

    typedef logic [1:0] code_type_t;
    localparam code_type_t TYPE_UNKNOWN = 2'd0;
    localparam code_type_t TYPE_ROOM    = 2'd1;
    localparam code_type_t TYPE_USER    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK_MIN,
        ST_CHK_REP,
        ST_CMP_RD,
        ST_CMP_EV,
        ST_LO_RD,
        ST_LO_EV,
        ST_HI_RD,
        ST_HI_EV,
        ST_CP_RD,
        ST_CP_WR,
        ST_EMPTY_LD,
        ST_EM_RD,
        ST_EM_LD
    } cldf_state_t;

    // Character at position pos (0 is the first) of a five-character prefix.
    function automatic logic [7:0] prefix_char(input logic [8*PREFIX_LEN-1:0] prefix,
                                               input logic [2:0] pos);
        logic [7:0] ch;
        ch = prefix[(PREFIX_LEN - 1 - int'(pos)) * 8 +: 8];
        return ch;
    endfunction

endpackage

// File: rtl/cldf_if.sv
// Valid/ready channel interfaces of the code line dedup filter: scanner input,
// code output and configuration write. Depends on cldf_pkg.
interface cldf_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink (input valid, input command, input rx_byte, output ready);
endinterface

interface cldf_out_if;
    logic                               valid;
    logic                               ready;
    logic [7:0]                         code_byte;
    cldf_pkg::code_type_t               code_type;
    logic [cldf_pkg::CODE_LEN_W-1:0]    code_length;
    logic                               empty_code;
    logic                               last_of_code;

    modport source (output valid, output code_byte, output code_type, output code_length,
                    output empty_code, output last_of_code, input ready);
    modport sink (input valid, input code_byte, input code_type, input code_length,
                  input empty_code, input last_of_code, output ready);
endinterface

interface cldf_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [cldf_pkg::CFG_IDX_W-1:0]    index;
    logic [cldf_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/code_line_dedup_filter_core.sv
// Code line dedup filter: collects scanner bytes into lines, rate limits and
// repeat filters them, trims spaces and emits the accepted code byte by byte.
// Depends on cldf_pkg and the channel interfaces in cldf_if.sv.
//
//   channel  dir  payload                                              transaction
//   rx       in   command, rx_byte                                     rx.valid & rx.ready
//   tx       out  code_byte, code_type, code_length, empty_code, last  tx.valid & tx.ready
//   cfg      in   index, data                                          cfg.valid & cfg.ready
//
// A tick or a data byte is taken while the sequencer is idle. A line end runs a sequencer
// over the line and prior code memories through a single registered read port per memory:
// the rate and repeat checks, the compare with the prior code, the scans over leading
// and trailing spaces, the copy of the trimmed code and its emission byte by byte.
// rx.ready is low while the sequencer runs; cfg.ready is always high.
// Reset clears the counters and loads the register defaults; memories are not cleared.
// A stalled tx holds the output register and the sequencer waits on it.
module code_line_dedup_filter_core #(
    parameter int MAX_LINE = cldf_pkg::MAX_LINE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    cldf_in_if.sink           rx,
    cldf_out_if.source        tx,
    cldf_cfg_if.sink          cfg
);
    import cldf_pkg::*;

    localparam int IW = $clog2(MAX_LINE);

    cldf_state_t state_reg, state_next;

    logic [IW-1:0]        line_count_reg, line_count_next;
    logic [IW-1:0]        prior_count_reg, prior_count_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [CFG_DATA_W-1:0] min_interval_reg, repeat_window_reg;

    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] lo_reg, lo_next;
    logic [IW-1:0] len_reg, len_next;
    logic          room_ok_reg, room_ok_next;
    logic          user_ok_reg, user_ok_next;

    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_byte_reg, out_byte_next;
    code_type_t            out_type_reg, out_type_next;
    logic [CODE_LEN_W-1:0] out_len_reg, out_len_next;
    logic                  out_empty_reg, out_empty_next;
    logic                  out_last_reg, out_last_next;

    logic [7:0] line_mem [MAX_LINE];
    logic [7:0] prior_mem [MAX_LINE];
    logic [7:0] line_rd_reg, prior_rd_reg;
    logic [IW-1:0] line_raddr;
    logic          line_wr_en, prior_wr_en;

    logic                 rx_fire;
    logic                 is_eol, is_print;
    logic                 out_free;
    logic [CFG_DATA_W-1:0] cmp_rhs;
    logic                 cmp_lt;
    logic [7:0]           byte_ref;
    logic                 byte_eq;
    logic                 idx_last_line, idx_last_code;
    logic                 long_enough;
    code_type_t           code_type_now;

    assign rx.ready  = (state_reg == ST_IDLE);
    assign rx_fire   = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    assign is_eol   = (rx.rx_byte == CHAR_LF) || (rx.rx_byte == CHAR_CR);
    assign is_print = (rx.rx_byte >= CHAR_SPACE) && (rx.rx_byte <= CHAR_TILDE);
    assign out_free = !out_valid_reg || tx.ready;

    // Shared threshold comparator for the rate limit and the repeat window.
    assign cmp_rhs = (state_reg == ST_CHK_MIN) ? min_interval_reg : repeat_window_reg;
    assign cmp_lt  = elapsed_reg < {1'b0, cmp_rhs};

    // Shared byte comparator: line against prior code, or line against a space.
    assign byte_ref = (state_reg == ST_CMP_EV) ? prior_rd_reg : CHAR_SPACE;
    assign byte_eq  = (line_rd_reg == byte_ref);

    assign idx_last_line = (idx_reg == line_count_reg - 1'b1);
    assign idx_last_code = (idx_reg == len_reg - 1'b1);
    assign long_enough   = (len_reg >= IW'(PREFIX_LEN));

    always_comb
    begin
        if (long_enough && room_ok_reg)
        begin
            code_type_now = TYPE_ROOM;
        end
        else if (long_enough && user_ok_reg)
        begin
            code_type_now = TYPE_USER;
        end
        else
        begin
            code_type_now = TYPE_UNKNOWN;
        end
    end

    assign line_raddr = (state_reg == ST_CP_RD) ? (lo_reg + idx_reg) : idx_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (rx_fire && !rx.command && is_eol && (line_count_reg != '0))
                begin
                    state_next = ST_CHK_MIN;
                end
            end
            ST_CHK_MIN:
            begin
                state_next = cmp_lt ? ST_IDLE : ST_CHK_REP;
            end
            ST_CHK_REP:
            begin
                state_next = (cmp_lt && (line_count_reg == prior_count_reg)) ? ST_CMP_RD
                                                                             : ST_LO_RD;
            end
            ST_CMP_RD:
            begin
                state_next = ST_CMP_EV;
            end
            ST_CMP_EV:
            begin
                if (!byte_eq)
                begin
                    state_next = ST_LO_RD;
                end
                else
                begin
                    state_next = idx_last_line ? ST_IDLE : ST_CMP_RD;
                end
            end
            ST_LO_RD:
            begin
                state_next = ST_LO_EV;
            end
            ST_LO_EV:
            begin
                if (byte_eq)
                begin
                    state_next = idx_last_line ? ST_EMPTY_LD : ST_LO_RD;
                end
                else
                begin
                    state_next = ST_HI_RD;
                end
            end
            ST_HI_RD:
            begin
                state_next = ST_HI_EV;
            end
            ST_HI_EV:
            begin
                state_next = byte_eq ? ST_HI_RD : ST_CP_RD;
            end
            ST_CP_RD:
            begin
                state_next = ST_CP_WR;
            end
            ST_CP_WR:
            begin
                state_next = idx_last_code ? ST_EM_RD : ST_CP_RD;
            end
            ST_EMPTY_LD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EM_RD:
            begin
                state_next = ST_EM_LD;
            end
            ST_EM_LD:
            begin
                if (out_free)
                begin
                    state_next = idx_last_code ? ST_IDLE : ST_EM_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and output register control.
    always_comb
    begin
        line_count_next  = line_count_reg;
        prior_count_next = prior_count_reg;
        elapsed_next     = elapsed_reg;
        idx_next         = idx_reg;
        lo_next          = lo_reg;
        len_next         = len_reg;
        room_ok_next     = room_ok_reg;
        user_ok_next     = user_ok_reg;
        line_wr_en       = 1'b0;
        prior_wr_en      = 1'b0;
        out_valid_next   = out_valid_reg && !tx.ready;
        out_byte_next    = out_byte_reg;
        out_type_next    = out_type_reg;
        out_len_next     = out_len_reg;
        out_empty_next   = out_empty_reg;
        out_last_next    = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (rx_fire)
                begin
                    if (rx.command)
                    begin
                        if (elapsed_reg != '1)
                        begin
                            elapsed_next = elapsed_reg + 1'b1;
                        end
                    end
                    else if (is_print)
                    begin
                        line_wr_en = 1'b1;
                        // A full buffer is thrown away.
                        if (line_count_reg == IW'(MAX_LINE - 1))
                        begin
                            line_count_next = '0;
                        end
                        else
                        begin
                            line_count_next = line_count_reg + 1'b1;
                        end
                    end
                end
            end
            ST_CHK_MIN:
            begin
                if (cmp_lt)
                begin
                    line_count_next = '0;
                end
            end
            ST_CMP_EV:
            begin
                if (!byte_eq)
                begin
                    idx_next = '0;
                end
                else if (idx_last_line)
                begin
                    line_count_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_LO_EV:
            begin
                if (byte_eq)
                begin
                    if (!idx_last_line)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    lo_next  = idx_reg;
                    idx_next = line_count_reg - 1'b1;
                end
            end
            ST_HI_EV:
            begin
                if (byte_eq)
                begin
                    idx_next = idx_reg - 1'b1;
                end
                else
                begin
                    len_next     = idx_reg - lo_reg + 1'b1;
                    idx_next     = '0;
                    room_ok_next = 1'b1;
                    user_ok_next = 1'b1;
                end
            end
            ST_CP_WR:
            begin
                prior_wr_en = 1'b1;
                if (idx_reg < IW'(PREFIX_LEN))
                begin
                    if (line_rd_reg != prefix_char(ROOM_PREFIX, idx_reg[2:0]))
                    begin
                        room_ok_next = 1'b0;
                    end
                    if (line_rd_reg != prefix_char(USER_PREFIX, idx_reg[2:0]))
                    begin
                        user_ok_next = 1'b0;
                    end
                end
                if (idx_last_code)
                begin
                    prior_count_next = len_reg;
                    elapsed_next     = '0;
                    line_count_next  = '0;
                    idx_next         = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_EMPTY_LD:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_byte_next    = '0;
                    out_type_next    = TYPE_UNKNOWN;
                    out_len_next     = '0;
                    out_empty_next   = 1'b1;
                    out_last_next    = 1'b1;
                    prior_count_next = '0;
                    elapsed_next     = '0;
                    line_count_next  = '0;
                end
            end
            ST_EM_LD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = prior_rd_reg;
                    out_type_next  = code_type_now;
                    out_len_next   = CODE_LEN_W'(len_reg);
                    out_empty_next = 1'b0;
                    out_last_next  = idx_last_code;
                    idx_next       = idx_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            line_count_reg  <= '0;
            prior_count_reg <= '0;
            elapsed_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            line_count_reg  <= line_count_next;
            prior_count_reg <= prior_count_next;
            elapsed_reg     <= elapsed_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg  <= MIN_INTERVAL_RST;
            repeat_window_reg <= REPEAT_WINDOW_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == CFG_MIN_INTERVAL)
            begin
                min_interval_reg <= cfg.data;
            end
            else if (cfg.index == CFG_REPEAT_WINDOW)
            begin
                repeat_window_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        lo_reg        <= lo_next;
        len_reg       <= len_next;
        room_ok_reg   <= room_ok_next;
        user_ok_reg   <= user_ok_next;
        out_byte_reg  <= out_byte_next;
        out_type_reg  <= out_type_next;
        out_len_reg   <= out_len_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
    end

    // Line buffer memory: written on each stored byte, one registered read port.
    always_ff @(posedge clk)
    begin
        if (line_wr_en)
        begin
            line_mem[line_count_reg] <= rx.rx_byte;
        end
        line_rd_reg <= line_mem[line_raddr];
    end

    // Prior code memory: written during the copy, read for compare and emission.
    always_ff @(posedge clk)
    begin
        if (prior_wr_en)
        begin
            prior_mem[idx_reg] <= line_rd_reg;
        end
        prior_rd_reg <= prior_mem[idx_reg];
    end

    assign tx.valid        = out_valid_reg;
    assign tx.code_byte    = out_byte_reg;
    assign tx.code_type    = out_type_reg;
    assign tx.code_length  = out_len_reg;
    assign tx.empty_code   = out_empty_reg;
    assign tx.last_of_code = out_last_reg;

endmodule
